// File: hw/rtl/nlmt_pkg.sv
// ----------------------------------------------------------------------------
// nlmt_pkg
// Shared types and constants for the scanned-network table.
// ----------------------------------------------------------------------------
package nlmt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int NAME_BYTES_DEF    = 32;

  localparam int NAME_WORDS = 4;
  localparam int NAME_W     = NAME_WORDS * 64;
  localparam int LEN_W      = 6;
  localparam int ADDR_W     = 48;
  localparam int QUAL_W     = 8;
  localparam int SEC_W      = 3;
  localparam int SRC_W      = 2;
  localparam int IDX_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int REQ_W      = 2;

  localparam int IN_LEN_LSB  = NAME_W;
  localparam int IN_ADDR_LSB = IN_LEN_LSB + LEN_W;
  localparam int IN_QUAL_LSB = IN_ADDR_LSB + ADDR_W;
  localparam int IN_SEC_LSB  = IN_QUAL_LSB + QUAL_W;
  localparam int IN_SRC_LSB  = IN_SEC_LSB + SEC_W;
  localparam int IN_IDX_LSB  = IN_SRC_LSB + SRC_W;
  localparam int IN_USED_W   = IN_IDX_LSB + IDX_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_USED_W  = COUNT_W + NAME_W + LEN_W + ADDR_W + QUAL_W + SEC_W + SRC_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic [QUAL_W-1:0] qual;
    logic [SEC_W-1:0]  sec;
    logic [SRC_W-1:0]  src;
  } rec_t;

  typedef struct packed {
    logic load;
    logic clr_cnt;
    logic scan_init;
    logic scan;
    logic rd_idx;
    logic merge;
    logic append;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic len_zero;
    logic idx_ok;
    logic hit;
    logic scan_done;
    logic full;
  } sts_t;

endpackage

// File: hw/rtl/nlmt_ctrl.sv
// ----------------------------------------------------------------------------
// nlmt_ctrl
// Request sequencer: dispatch, table scan, merge or append, result handoff.
// ----------------------------------------------------------------------------
module nlmt_ctrl
  import nlmt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MERGE  = 6'b001000,
    S_APPEND = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        case (sts.req)
          REQ_CLEAR: begin
            cmd.clr_cnt = 1'b1;
          end
          REQ_ADD: begin
            if (!sts.len_zero) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          REQ_READ: begin
            cmd.rd_idx = sts.idx_ok;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_MERGE;
        end else if (sts.scan_done) begin
          state_nxt = sts.full ? S_RESP : S_APPEND;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_RESP;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/nlmt_dp.sv
// ----------------------------------------------------------------------------
// nlmt_dp
// Request registers, record memory, name compare, merge and fill count.
// ----------------------------------------------------------------------------
module nlmt_dp
  import nlmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic [REQ_W-1:0]     in_req,
  input  logic [SRC_W-1:0]     radio_code,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 res_acc,
  output logic [COUNT_W-1:0]   res_count,
  output rec_t                 res_rec
);

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  rec_t rec_mem [TABLE_ENTRIES];

  logic [NAME_W-1:0] name_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] addr_r;
  logic [QUAL_W-1:0] qual_r;
  logic [SEC_W-1:0]  sec_r;
  logic [SRC_W-1:0]  src_r;
  logic [IDX_W-1:0]  idx_r;
  req_t              req_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     scan_r;
  logic              cmp_vld_r;
  logic [AW-1:0]     cmp_ptr_r;
  logic              acc_r;
  logic              rd_ok_r;
  rec_t              rd_data_r;

  logic [LEN_W-1:0]  len_in;
  logic [LEN_W-1:0]  len_c;
  logic [NAME_W-1:0] name_c;
  logic              match;
  logic              issue;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  rec_t              wr_data;
  rec_t              merged;
  rec_t              key_rec;

  always_comb begin
    len_in = in_data[IN_LEN_LSB +: LEN_W];
    len_c  = (len_in > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : len_in;
    for (int b = 0; b < NAME_W / 8; b++) begin
      name_c[b*8 +: 8] = (LEN_W'(b) < len_c) ? in_data[b*8 +: 8] : 8'd0;
    end
  end

  assign key_rec = '{name: name_r, len: len_r, addr: addr_r, qual: qual_r,
                     sec: sec_r, src: src_r};

  assign match = (rd_data_r.name == name_r) && (rd_data_r.len == len_r);

  always_comb begin
    merged = rd_data_r;
    if (qual_r > rd_data_r.qual) begin
      merged.qual = qual_r;
    end
    if (sec_r > rd_data_r.sec) begin
      merged.sec = sec_r;
    end
    if (src_r == radio_code) begin
      merged.src  = src_r;
      merged.addr = addr_r;
    end
  end

  always_comb begin
    sts.req       = req_r;
    sts.len_zero  = (len_r == '0);
    sts.idx_ok    = (CMPW'(idx_r) < CMPW'(count_r));
    sts.hit       = cmp_vld_r && match;
    sts.scan_done = !cmp_vld_r && (scan_r == count_r);
    sts.full      = (count_r == CW'(TABLE_ENTRIES));
  end

  always_comb begin
    issue   = cmd.scan && !(cmp_vld_r && match) && (scan_r < count_r);
    rd_en   = issue || cmd.rd_idx;
    rd_addr = cmd.rd_idx ? AW'(idx_r) : scan_r[AW-1:0];
    wr_en   = cmd.merge || cmd.append;
    wr_addr = cmd.merge ? cmp_ptr_r : count_r[AW-1:0];
    wr_data = cmd.merge ? merged : key_rec;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= rec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req);
      name_r <= name_c;
      len_r  <= len_c;
      addr_r <= in_data[IN_ADDR_LSB +: ADDR_W];
      qual_r <= in_data[IN_QUAL_LSB +: QUAL_W];
      sec_r  <= in_data[IN_SEC_LSB +: SEC_W];
      src_r  <= in_data[IN_SRC_LSB +: SRC_W];
      idx_r  <= in_data[IN_IDX_LSB +: IDX_W];
    end
    if (issue) begin
      cmp_ptr_r <= scan_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
      acc_r     <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc_r   <= 1'b0;
        rd_ok_r <= 1'b0;
      end
      if (cmd.clr_cnt) begin
        count_r <= '0;
      end
      if (cmd.scan_init) begin
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
      end
      if (cmd.scan) begin
        cmp_vld_r <= issue;
        if (issue) begin
          scan_r <= scan_r + 1'b1;
        end
      end
      if (cmd.rd_idx) begin
        acc_r   <= 1'b1;
        rd_ok_r <= 1'b1;
      end
      if (cmd.merge) begin
        acc_r <= 1'b1;
      end
      if (cmd.append) begin
        acc_r   <= 1'b1;
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign res_acc   = acc_r;
  assign res_count = COUNT_W'(count_r);
  assign res_rec   = rd_ok_r ? rd_data_r : '0;

endmodule

// File: hw/rtl/network_list_merge_table_core.sv
// ----------------------------------------------------------------------------
// network_list_merge_table_core
// Scanned-network table keyed by name: clear, add-or-merge, read by index.
//
//   channel | dir | handshake             | payload
//   in_     | in  | in_tvalid/in_tready   | in_tuser: request, in_tdata: item
//   out_    | out | out_tvalid/out_tready | out_tuser: accepted, out_tdata: rec
//   cfg_    | in  | APB, pready tied high | radio source code at offset 0
//
// One item at a time. Clear, read and unknown requests need no scan; an add
// scans the stored names through the single read port of the record memory,
// one entry a cycle, until a name matches or every entry has been compared.
// in_tready is high only while idle; out_tvalid holds until taken. Reset
// empties the table (fill count only); records need no clearing.
// ----------------------------------------------------------------------------
module network_list_merge_table_core
  import nlmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // name_word0..3, name_length, station_address, link_quality,
  // security_level, source_code, entry_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // entry_count, out_name_word0..3, out_name_length, out_station_address,
  // out_link_quality, out_security_level, out_source_code
  output logic [OUT_DATA_W-1:0] out_tdata,
  // accepted
  output logic [0:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [SRC_W-1:0]   radio_code_r;
  cmd_t               cmd;
  sts_t               sts;
  logic               res_acc;
  logic [COUNT_W-1:0] res_count;
  rec_t               res_rec;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-SRC_W){1'b0}}, radio_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_code_r <= SRC_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      radio_code_r <= cfg_pwdata[SRC_W-1:0];
    end
  end

  nlmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nlmt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .in_req     (in_tuser),
    .radio_code (radio_code_r),
    .cmd        (cmd),
    .sts        (sts),
    .res_acc    (res_acc),
    .res_count  (res_count),
    .res_rec    (res_rec)
  );

  assign out_tuser = res_acc;
  assign out_tdata = OUT_DATA_W'({res_rec.src, res_rec.sec, res_rec.qual, res_rec.addr,
                                  res_rec.len, res_rec.name, res_count});

endmodule
